// ===== hdl/rpl_pkg.sv =====
package rpl_pkg;

	localparam int DMEM_DEPTH = 1024;
	localparam int DMEM_AW    = $clog2(DMEM_DEPTH);
	localparam int NUM_REGS   = 32;
	localparam int REG_AW     = $clog2(NUM_REGS);
	localparam int XLEN       = 32;
	localparam int HALF       = 16;
	localparam int OUT_AW     = 10;

	localparam logic [5:0] OP_RTYPE = 6'h00;
	localparam logic [5:0] OP_LOAD  = 6'h20;
	localparam logic [5:0] OP_STORE = 6'h28;
	localparam logic [5:0] FN_ADD   = 6'h20;
	localparam logic [5:0] FN_SUB   = 6'h22;

	localparam logic [XLEN-1:0] REG_BASE = 32'h0000_0100;

	typedef enum logic [2:0] {
		K_NONE,
		K_LOAD,
		K_STORE,
		K_ADD,
		K_SUB
	} kind_t;

	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] idx;
		logic [XLEN-1:0]   data;
	} rf_wr_t;

	typedef struct packed {
		logic               ld;
		logic               st;
		logic [DMEM_AW-1:0] addr;
		logic [HALF-1:0]    data;
	} dm_req_t;

	typedef struct packed {
		logic [XLEN-1:0]   retire_pc;
		logic [HALF-1:0]   mem_write_data;
		logic [OUT_AW-1:0] mem_write_addr;
		logic              mem_write_valid;
		logic [XLEN-1:0]   reg_write_value;
		logic [REG_AW-1:0] reg_write_index;
		logic              reg_write_valid;
	} result_t;

	function automatic kind_t decode_kind(input logic [XLEN-1:0] w);
		kind_t k;
		k = K_NONE;
		unique case (w[31:26])
			OP_LOAD:  k = K_LOAD;
			OP_STORE: k = K_STORE;
			OP_RTYPE: begin
				unique case (w[5:0])
					FN_ADD:  k = K_ADD;
					FN_SUB:  k = K_SUB;
					default: k = K_NONE;
				endcase
			end
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	function automatic logic [XLEN-1:0] rf_reset_val(input logic [REG_AW-1:0] i);
		return (i == '0) ? '0 : REG_BASE + XLEN'(i);
	endfunction

endpackage

// ===== hdl/risc_pipeline_load_store_add_sub.sv =====
// Five-stage in-order core (fetch, decode/register read, execute, memory, writeback) with
// no forwarding and no hazard stalls. Each input transaction carries one fetched word and its
// address and advances every stage by one; each advance yields exactly one output
// transaction that reports the writeback and store activity of that step. One transaction
// per clock is sustained; the only limits are the output register handshake and the
// data memory clear after reset, which initializes all 1024 words (one word per cycle)
// while s_tready stays low. The register file and data memory are synchronous-read
// RAMs; register reads are issued at decode and land in execute.
module risc_pipeline_load_store_add_sub
	import rpl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [63:0]  s_tdata,   // instr_word[31:0], fetch_pc[63:32]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [103:0] m_tdata    // reg_write_valid, reg_write_index, reg_write_value,
	                                // mem_write_valid, mem_write_addr, mem_write_data,
	                                // retire_pc, zero pad
);

	logic adv;
	logic dm_busy;

	logic [XLEN-1:0] instr_word, fetch_pc;

	logic            v_s1;
	logic [XLEN-1:0] word_s1, pc_s1;

	kind_t             dec_kind;
	logic              v_s2;
	kind_t             kind_s2;
	logic [REG_AW-1:0] dest_s2;
	logic [XLEN-1:0]   off_s2, pc_s2;
	logic [XLEN-1:0]   opa, opb, alu;

	logic              v_s3;
	kind_t             kind_s3;
	logic [REG_AW-1:0] dest_s3;
	logic [XLEN-1:0]   alu_s3, pc_s3;
	logic [HALF-1:0]   sval_s3;

	logic              v_s4, wr_s4, ld_s4;
	logic [REG_AW-1:0] dest_s4;
	logic [XLEN-1:0]   value_s4, pc_s4;

	dm_req_t         dm_req;
	logic [HALF-1:0] dm_rdata;
	rf_wr_t          rf_wr;
	logic            st_do;
	result_t         res, out_q;
	logic            m_tvalid_q;

	assign instr_word = s_tdata[31:0];
	assign fetch_pc   = s_tdata[63:32];

	assign s_tready = !dm_busy && (!m_tvalid_q || m_tready);
	assign adv      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= instr_word != '0;
			v_s2 <= v_s1 && dec_kind != K_NONE;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign dec_kind = decode_kind(word_s1);

	always_comb begin
		case (kind_s2)
			K_ADD:   alu = opa + opb;
			K_SUB:   alu = opa - opb;
			default: alu = opa + off_s2;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_s1  <= instr_word;
			pc_s1    <= fetch_pc + 32'd4;
			kind_s2  <= dec_kind;
			dest_s2  <= (dec_kind == K_ADD || dec_kind == K_SUB) ? word_s1[15:11]
			                                                     : word_s1[20:16];
			off_s2   <= {{HALF{word_s1[15]}}, word_s1[15:0]};
			pc_s2    <= pc_s1;
			kind_s3  <= kind_s2;
			dest_s3  <= dest_s2;
			alu_s3   <= alu;
			sval_s3  <= opb[HALF-1:0];
			pc_s3    <= pc_s2;
			wr_s4    <= kind_s3 != K_STORE;
			ld_s4    <= kind_s3 == K_LOAD;
			dest_s4  <= dest_s3;
			value_s4 <= alu_s3;
			pc_s4    <= pc_s3;
		end
	end

	rpl_regfile u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (adv),
		.rs_idx  (word_s1[25:21]),
		.rt_idx  (word_s1[20:16]),
		.wr      (rf_wr),
		.rs_data (opa),
		.rt_data (opb)
	);

	assign st_do       = v_s3 && kind_s3 == K_STORE;
	assign dm_req.ld   = adv && v_s3 && kind_s3 == K_LOAD;
	assign dm_req.st   = adv && st_do;
	assign dm_req.addr = alu_s3[DMEM_AW-1:0];
	assign dm_req.data = sval_s3;

	rpl_dmem u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dm_req),
		.rdata  (dm_rdata),
		.busy   (dm_busy)
	);

	always_comb begin
		res.reg_write_valid = v_s4 && wr_s4 && dest_s4 != '0;
		res.reg_write_index = res.reg_write_valid ? dest_s4 : '0;
		res.reg_write_value = '0;
		if (res.reg_write_valid) begin
			res.reg_write_value = ld_s4 ? XLEN'(dm_rdata) : value_s4;
		end
		res.mem_write_valid = st_do;
		res.mem_write_addr  = st_do ? OUT_AW'(alu_s3[DMEM_AW-1:0]) : '0;
		res.mem_write_data  = st_do ? sval_s3 : '0;
		res.retire_pc       = v_s4 ? pc_s4 : '0;
	end

	assign rf_wr.en   = adv && res.reg_write_valid;
	assign rf_wr.idx  = res.reg_write_index;
	assign rf_wr.data = res.reg_write_value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'b0, out_q};

`ifndef SYNTHESIS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_tvalid)
		else $error("accepted transaction produced no result");
	a_no_adv_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		dm_busy |-> !s_tready)
		else $error("input taken during memory clear");
	a_r0_not_reported: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && out_q.reg_write_valid |-> out_q.reg_write_index != '0)
		else $error("write to register zero reported");
	a_bubble_in: assert property (@(posedge clk) disable iff (!arst_n)
		adv && instr_word == '0 |=> !v_s1)
		else $error("zero word entered as valid");
`endif

endmodule

// ===== hdl/rpl_regfile.sv =====
module rpl_regfile
	import rpl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [REG_AW-1:0] rs_idx,
	input  logic [REG_AW-1:0] rt_idx,
	input  rf_wr_t            wr,
	output logic [XLEN-1:0]   rs_data,
	output logic [XLEN-1:0]   rt_data
);

	logic [XLEN-1:0]   mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [XLEN-1:0]   rs_raw_q, rt_raw_q;
	logic              rs_vld_q, rt_vld_q;
	logic [REG_AW-1:0] rs_idx_q, rt_idx_q;

	// read returns contents from before a write at the same edge
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx] <= wr.data;
		end
		if (rd_en) begin
			rs_raw_q <= mem[rs_idx];
			rt_raw_q <= mem[rt_idx];
			rs_vld_q <= vld_q[rs_idx];
			rt_vld_q <= vld_q[rt_idx];
			rs_idx_q <= rs_idx;
			rt_idx_q <= rt_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr.en) begin
			vld_q[wr.idx] <= 1'b1;
		end
	end

	assign rs_data = rs_vld_q ? rs_raw_q : rf_reset_val(rs_idx_q);
	assign rt_data = rt_vld_q ? rt_raw_q : rf_reset_val(rt_idx_q);

`ifndef SYNTHESIS
	a_no_r0_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> wr.idx != '0)
		else $error("register zero written");
	a_r0_never_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q[0])
		else $error("register zero marked written");
	a_vld_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> vld_q[$past(wr.idx)])
		else $error("written register not marked valid");
`endif

endmodule

// ===== hdl/rpl_dmem.sv =====
module rpl_dmem
	import rpl_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  dm_req_t         req,
	output logic [HALF-1:0] rdata,
	output logic            busy
);

	logic [HALF-1:0]    mem [DMEM_DEPTH];
	logic [HALF-1:0]    rdata_q;
	logic [DMEM_AW-1:0] clr_q;
	logic               busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_q  <= '0;
		end else if (busy_q) begin
			if (clr_q == DMEM_AW'(DMEM_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_q] <= HALF'(clr_q) & HALF'(8'hFF);
		end else if (req.st) begin
			mem[req.addr] <= req.data;
		end
		if (req.ld) begin
			rdata_q <= mem[req.addr];
		end
	end

	assign rdata = rdata_q;
	assign busy  = busy_q;

`ifndef SYNTHESIS
	a_no_access_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !req.ld && !req.st)
		else $error("access during clear pass");
	a_ld_st_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ld && req.st))
		else $error("load and store in one cycle");
	a_clear_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && clr_q == DMEM_AW'(DMEM_DEPTH - 1) |=> !busy_q)
		else $error("clear pass did not end");
`endif

endmodule

// ===== tb/pipe_writeback_checker.sv =====
`timescale 1ns / 1ps

module pipe_writeback_checker
	import rpl_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [63:0]  s_tdata,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [103:0] m_tdata,
	output int           fails,
	output int           pending
);

	typedef struct packed {
		logic            valid;
		logic [XLEN-1:0] word;
		logic [XLEN-1:0] pc;
	} if_id_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [REG_AW-1:0] dest;
		logic [XLEN-1:0]   offset;
		logic [XLEN-1:0]   a;
		logic [XLEN-1:0]   b;
		logic [XLEN-1:0]   pc;
	} id_ex_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [REG_AW-1:0] dest;
		logic [XLEN-1:0]   alu;
		logic [XLEN-1:0]   sval;
		logic [XLEN-1:0]   pc;
	} ex_mem_t;

	typedef struct packed {
		logic              valid;
		logic              wr;
		logic [REG_AW-1:0] dest;
		logic [XLEN-1:0]   value;
		logic [XLEN-1:0]   pc;
	} mem_wb_t;

	logic [XLEN-1:0] gpr [NUM_REGS];
	logic [HALF-1:0] dmem [DMEM_DEPTH];
	if_id_t          if_id;
	id_ex_t          id_ex;
	ex_mem_t         ex_mem;
	mem_wb_t         mem_wb;
	result_t         writeback_q [$];

	function automatic kind_t classify(input logic [XLEN-1:0] w);
		kind_t k;
		k = K_NONE;
		if (w[31:26] == OP_LOAD) begin
			k = K_LOAD;
		end else if (w[31:26] == OP_STORE) begin
			k = K_STORE;
		end else if (w[31:26] == OP_RTYPE && w[5:0] == FN_ADD) begin
			k = K_ADD;
		end else if (w[31:26] == OP_RTYPE && w[5:0] == FN_SUB) begin
			k = K_SUB;
		end
		return k;
	endfunction

	task automatic reset_core();
		for (int i = 0; i < NUM_REGS; i++) begin
			gpr[i] = (i == 0) ? '0 : REG_BASE + XLEN'(i);
		end
		for (int i = 0; i < DMEM_DEPTH; i++) begin
			dmem[i] = HALF'(i % 256);
		end
		if_id  = '0;
		id_ex  = '0;
		ex_mem = '0;
		mem_wb = '0;
	endtask

	// one pipeline advance per accepted input; decode reads the register file before writeback lands
	task automatic advance_core(input logic [XLEN-1:0] word, input logic [XLEN-1:0] pc,
			output result_t res);
		if_id_t             nf;
		id_ex_t             nd;
		ex_mem_t            ne;
		mem_wb_t            nm;
		logic [DMEM_AW-1:0] addr;
		kind_t              k;
		res = '0;
		if (mem_wb.valid) begin
			res.retire_pc = mem_wb.pc;
			if (mem_wb.wr && mem_wb.dest != '0) begin
				res.reg_write_valid = 1'b1;
				res.reg_write_index = mem_wb.dest;
				res.reg_write_value = mem_wb.value;
			end
		end

		nm = '0;
		if (ex_mem.valid) begin
			addr     = ex_mem.alu[DMEM_AW-1:0];
			nm.valid = 1'b1;
			nm.pc    = ex_mem.pc;
			nm.dest  = ex_mem.dest;
			if (ex_mem.kind == K_STORE) begin
				res.mem_write_valid = 1'b1;
				res.mem_write_addr  = addr;
				res.mem_write_data  = ex_mem.sval[HALF-1:0];
				dmem[addr]          = ex_mem.sval[HALF-1:0];
			end else if (ex_mem.kind == K_LOAD) begin
				nm.wr    = 1'b1;
				nm.value = {{(XLEN-HALF){1'b0}}, dmem[addr]};
			end else begin
				nm.wr    = 1'b1;
				nm.value = ex_mem.alu;
			end
		end

		ne = '0;
		if (id_ex.valid) begin
			ne.valid = 1'b1;
			ne.kind  = id_ex.kind;
			ne.dest  = id_ex.dest;
			ne.pc    = id_ex.pc;
			ne.sval  = id_ex.b;
			case (id_ex.kind)
				K_ADD:   ne.alu = id_ex.a + id_ex.b;
				K_SUB:   ne.alu = id_ex.a - id_ex.b;
				default: ne.alu = id_ex.a + id_ex.offset;
			endcase
		end

		nd = '0;
		k  = classify(if_id.word);
		if (if_id.valid && k != K_NONE) begin
			nd.valid  = 1'b1;
			nd.kind   = k;
			nd.pc     = if_id.pc;
			nd.offset = {{(XLEN-16){if_id.word[15]}}, if_id.word[15:0]};
			nd.dest   = (k == K_ADD || k == K_SUB) ? if_id.word[15:11] : if_id.word[20:16];
			nd.a      = gpr[if_id.word[25:21]];
			nd.b      = gpr[if_id.word[20:16]];
		end

		nf.valid = (word != '0);
		nf.word  = word;
		nf.pc    = pc + 32'd4;

		if (res.reg_write_valid) begin
			gpr[res.reg_write_index] = res.reg_write_value;
		end
		if_id  = nf;
		id_ex  = nd;
		ex_mem = ne;
		mem_wb = nm;
	endtask

	task automatic compare_field(input string field, input logic [XLEN-1:0] want,
			input logic [XLEN-1:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h, got %h", $time, field, want, got);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		result_t predicted;
		result_t want;
		result_t got;
		if (!arst_n) begin
			reset_core();
			writeback_q.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				advance_core(s_tdata[31:0], s_tdata[63:32], predicted);
				writeback_q.push_back(predicted);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(result_t)-1:0];
				if (writeback_q.size() == 0) begin
					$display("%0t ns: unexpected transaction, expected none, got %h", $time, got);
					fails++;
				end else begin
					want = writeback_q.pop_front();
					compare_field("reg_write_valid", want.reg_write_valid, got.reg_write_valid);
					compare_field("reg_write_index", want.reg_write_index, got.reg_write_index);
					compare_field("reg_write_value", want.reg_write_value, got.reg_write_value);
					compare_field("mem_write_valid", want.mem_write_valid, got.mem_write_valid);
					compare_field("mem_write_addr", want.mem_write_addr, got.mem_write_addr);
					compare_field("mem_write_data", want.mem_write_data, got.mem_write_data);
					compare_field("retire_pc", want.retire_pc, got.retire_pc);
				end
			end
			pending = writeback_q.size();
		end
	end

endmodule

// ===== tb/tb_risc_pipeline_load_store_add_sub.sv =====
`timescale 1ns / 1ps

module tb_risc_pipeline_load_store_add_sub;
	import rpl_pkg::*;

	localparam int         STALL_LIMIT = 20000;
	localparam int         N_RANDOM    = 500;
	localparam logic [5:0] OP_UNDEF    = 6'h3F;
	localparam logic [5:0] FN_UNDEF    = 6'h21;

	logic         clk = 1'b0;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [63:0]  s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [103:0] m_tdata;

	int           fails;
	int           pending;
	int           stall_cycles = 0;
	logic         calm;
	logic [31:0]  fetch_addr;
	logic [31:0]  pick_pc;

	always #6 clk = ~clk;

	risc_pipeline_load_store_add_sub uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	pipe_writeback_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.fails    (fails),
		.pending  (pending)
	);

	function automatic logic [31:0] mk_i(input logic [5:0] op, input logic [4:0] rs,
			input logic [4:0] rt, input logic [15:0] imm);
		return {op, rs, rt, imm};
	endfunction

	function automatic logic [31:0] mk_r(input logic [4:0] rs, input logic [4:0] rt,
			input logic [4:0] rd, input logic [5:0] fn);
		return {OP_RTYPE, rs, rt, rd, 5'd0, fn};
	endfunction

	// mostly well-formed instructions, some bubbles and raw noise
	function automatic logic [31:0] rand_instr();
		logic [4:0]  rs;
		logic [4:0]  rt;
		logic [4:0]  rd;
		logic [4:0]  sh;
		logic [15:0] imm;
		int          pick;
		rs   = 5'($urandom);
		rt   = 5'($urandom);
		rd   = 5'($urandom);
		sh   = 5'($urandom);
		imm  = ($urandom_range(0, 1) == 0) ? 16'($urandom)
		                                   : 16'($urandom_range(0, 15) - 8);
		pick = $urandom_range(0, 99);
		if (pick < 22) begin
			return mk_i(OP_LOAD, rs, rt, imm);
		end else if (pick < 44) begin
			return mk_i(OP_STORE, rs, rt, imm);
		end else if (pick < 63) begin
			return {OP_RTYPE, rs, rt, rd, sh, FN_ADD};
		end else if (pick < 82) begin
			return {OP_RTYPE, rs, rt, rd, sh, FN_SUB};
		end else if (pick < 90) begin
			return '0;
		end
		return $urandom;
	endfunction

	task automatic issue(input logic [31:0] w, input logic [31:0] pc);
		while (!calm && $urandom_range(0, 99) < 30) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {pc, w};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		fetch_addr = pc + 32'd4;
	endtask

	// hold off the sender until every outstanding transaction has come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 30);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		while (stall_cycles < STALL_LIMIT) @(posedge clk);
		$display("risc_pipeline_load_store_add_sub: mismatch");
		$finish;
	end

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		calm       = 1'b0;
		fetch_addr = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		issue('0, 32'h0);
		issue(mk_i(OP_LOAD, 5'd0, 5'd1, 16'h0000), fetch_addr);
		issue(mk_i(OP_LOAD, 5'd3, 5'd2, 16'hFFFF), fetch_addr);
		issue(mk_i(OP_STORE, 5'd4, 5'd5, 16'h0005), fetch_addr);
		issue(mk_r(5'd7, 5'd8, 5'd6, FN_ADD), fetch_addr);
		issue(mk_r(5'd10, 5'd11, 5'd9, FN_SUB), fetch_addr);
		issue(mk_r(5'd9, 5'd9, 5'd14, FN_ADD), fetch_addr);      // reads r9 before the sub retires
		issue(mk_r(5'd1, 5'd2, 5'd0, FN_ADD), fetch_addr);       // write to r0 dropped
		issue(mk_i(OP_LOAD, 5'd5, 5'd0, 16'h0003), fetch_addr);
		issue('1, fetch_addr);                                   // undefined opcode
		issue(mk_r(5'd1, 5'd2, 5'd3, FN_UNDEF), fetch_addr);
		issue(mk_i(OP_UNDEF, 5'd6, 5'd7, 16'h1234), fetch_addr);
		issue(mk_r(5'd12, 5'd13, 5'd15, FN_ADD), 32'hFFFF_FFFC); // pc + 4 wraps to zero
		issue(mk_i(OP_LOAD, 5'd31, 5'd16, 16'h7FFF), 32'hFFFF_FFFF);
		issue(mk_i(OP_STORE, 5'd31, 5'd30, 16'h8000), fetch_addr);
		issue(mk_i(OP_STORE, 5'd17, 5'd0, 16'hFFFF), fetch_addr);
		repeat (3) issue('0, fetch_addr);
		issue(mk_i(OP_LOAD, 5'd4, 5'd18, 16'h0005), fetch_addr);
		issue(mk_r(5'd20, 5'd20, 5'd19, FN_SUB), fetch_addr);
		issue(mk_r(5'd31, 5'd31, 5'd31, FN_ADD), fetch_addr);
		repeat (3) issue('0, fetch_addr);
		drain();

		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 200 && n < 350);
			if (n == 250) begin
				drain();
			end
			pick_pc = ($urandom_range(0, 9) == 0) ? $urandom : fetch_addr;
			issue(rand_instr(), pick_pc);
		end
		calm = 1'b0;
		s_tvalid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (12) @(negedge clk);
		if (fails == 0) begin
			$display("risc_pipeline_load_store_add_sub: match");
		end else begin
			$display("risc_pipeline_load_store_add_sub: mismatch");
		end
		$finish;
	end

endmodule
